[rtl/sspt_pkg.sv]
package sspt_pkg;

  // fixed field widths of the request and result channels
  localparam int unsigned TOGGLE_W  = 6;
  localparam int unsigned SETSZ_W   = 6;
  localparam int unsigned SUMSET_W  = 7;
  localparam int unsigned PRODSET_W = 12;

  // representation counts wrap within this width
  localparam int unsigned REP_W = 6;

  // count steps: ordered pair of two members, and a member paired with itself
  localparam int unsigned DELTA_PAIR = 2;
  localparam int unsigned DELTA_SELF = 1;

  // result of one read-modify-write of a representation count
  typedef struct packed {
    logic [REP_W-1:0] count;
    logic             rise;
    logic             fall;
  } rep_upd_t;

endpackage

[rtl/sspt_ram.sv]
module sspt_ram import sspt_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/sspt_rep_upd.sv]
module sspt_rep_upd import sspt_pkg::*; (
  input  logic [REP_W-1:0] old_i,
  input  logic             add_i,
  input  logic             self_i,
  output rep_upd_t         upd_o
);

  logic [REP_W-1:0] delta;
  logic [REP_W-1:0] new_count;

  // step by one for the self pair, by two for a pair of distinct members
  assign delta     = self_i ? REP_W'(DELTA_SELF) : REP_W'(DELTA_PAIR);
  assign new_count = add_i ? (old_i + delta) : (old_i - delta);

  // a count leaving zero adds a distinct value, one reaching zero drops it
  assign upd_o.count = new_count;
  assign upd_o.rise  = add_i && (old_i == '0);
  assign upd_o.fall  = !add_i && (new_count == '0);

endmodule

[rtl/sumset_productset_tracker_core.sv]
// channel  | handshake                | payload
// ---------+--------------------------+------------------------------------------------
// request  | in_valid_i / in_ready_o  | toggle_value_i
// result   | out_valid_o / out_ready_i| set_size_o, sumset_size_o, productset_size_o,
//          |                          | was_added_o
//
// an in-range request walks the member list one member per cycle, then the self pair,
// through the shared add/multiply stage and the count read-modify-write stage
// an out-of-range request goes straight to the result and changes nothing
// after reset the count memories are cleared, max(2*MAX_ELEM+1, MAX_ELEM^2+1) slots
// (3970 at the default); in_ready_o stays low meanwhile
// a new request is taken while a finished result still waits in the output register;
// a stalled result holds the block only when the next result is ready to leave
module sumset_productset_tracker_core import sspt_pkg::*; #(
  parameter int unsigned MAX_ELEM = 63
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [TOGGLE_W-1:0]  toggle_value_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [SETSZ_W-1:0]   set_size_o,
  output logic [SUMSET_W-1:0]  sumset_size_o,
  output logic [PRODSET_W-1:0] productset_size_o,
  output logic                 was_added_o
);

  localparam int unsigned SUM_SLOTS  = 2 * MAX_ELEM + 1;
  localparam int unsigned PROD_SLOTS = MAX_ELEM * MAX_ELEM + 1;
  localparam int unsigned CLR_SLOTS  = (SUM_SLOTS > PROD_SLOTS) ? SUM_SLOTS : PROD_SLOTS;
  localparam int unsigned POS_AW     = $clog2(MAX_ELEM + 1);
  localparam int unsigned CNT_W      = POS_AW;
  localparam int unsigned LIST_AW    = (MAX_ELEM > 1) ? $clog2(MAX_ELEM) : 1;
  localparam int unsigned SUM_AW     = $clog2(SUM_SLOTS);
  localparam int unsigned PROD_AW    = $clog2(PROD_SLOTS);
  localparam int unsigned CLR_AW     = $clog2(CLR_SLOTS);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_WALK   = 6'b000100,
    ST_DRAIN  = 6'b001000,
    ST_UPDATE = 6'b010000,
    ST_FINISH = 6'b100000
  } state_e;

  typedef struct packed {
    logic valid;
    logic self;
    logic last;
  } iss_t;

  typedef struct packed {
    logic               valid;
    logic               self;
    logic [SUM_AW-1:0]  sum_addr;
    logic [PROD_AW-1:0] prod_addr;
  } rmw_t;

  state_e               state_q, state_d;
  logic [CLR_AW-1:0]    clr_q, clr_d;
  logic [CNT_W-1:0]     idx_q, idx_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [MAX_ELEM-1:0]  mask_q, mask_d;
  logic [SUM_AW-1:0]    dsum_q, dsum_d;
  logic [PROD_AW-1:0]   dprod_q, dprod_d;
  logic [POS_AW-1:0]    x_q, x_d;
  logic                 del_q, del_d;
  logic                 add_q, add_d;
  logic [POS_AW-1:0]    last_q, last_d;
  iss_t                 iss_q, iss_d;
  rmw_t                 s2_q, s2_d;
  logic                 out_valid_q, out_valid_d;
  logic [SETSZ_W-1:0]   set_size_q;
  logic [SUMSET_W-1:0]  sumset_q;
  logic [PRODSET_W-1:0] prodset_q;
  logic                 added_q;

  logic                 in_fire;
  logic                 in_range;
  logic [POS_AW-1:0]    in_x;
  logic [POS_AW-1:0]    in_xm1;
  logic [POS_AW-1:0]    x_m1;
  logic                 out_load;
  logic                 clearing;

  logic [POS_AW-1:0]    list_rdata;
  logic                 list_we;
  logic [LIST_AW-1:0]   list_waddr;
  logic [POS_AW-1:0]    list_wdata;
  logic [LIST_AW-1:0]   pos_rdata;
  logic                 pos_we;
  logic [POS_AW-1:0]    pos_waddr;
  logic [LIST_AW-1:0]   pos_wdata;
  logic [POS_AW-1:0]    pos_raddr;

  logic [POS_AW-1:0]    s1_y;
  logic                 s1_go;
  logic [POS_AW:0]      s1_sum;
  logic [2*POS_AW-1:0]  s1_prod;
  logic [SUM_AW-1:0]    s1_sum_addr;
  logic [PROD_AW-1:0]   s1_prod_addr;

  logic [REP_W-1:0]     sum_rdata, prod_rdata;
  rep_upd_t             sum_upd, prod_upd;
  logic                 sum_we, prod_we;
  logic [SUM_AW-1:0]    sum_waddr;
  logic [PROD_AW-1:0]   prod_waddr;
  logic [REP_W-1:0]     sum_wdata, prod_wdata;

  // request decode
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign in_range   = (toggle_value_i != '0) && (toggle_value_i <= TOGGLE_W'(MAX_ELEM));
  assign in_x       = toggle_value_i[POS_AW-1:0];
  assign in_xm1     = in_x - POS_AW'(1);
  assign x_m1       = x_q - POS_AW'(1);
  assign clearing   = (state_q == ST_CLEAR);
  assign out_load   = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);

  // sequencer
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    mask_d      = mask_q;
    x_d         = x_q;
    del_d       = del_q;
    add_d       = add_q;
    iss_d       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    list_we     = 1'b0;
    pos_we      = 1'b0;
    list_waddr  = cnt_q[LIST_AW-1:0];
    list_wdata  = x_q;
    pos_waddr   = x_q;
    pos_wdata   = cnt_q[LIST_AW-1:0];
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + CLR_AW'(1);
        if (clr_q == CLR_AW'(CLR_SLOTS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          x_d   = in_x;
          idx_d = '0;
          if (in_range) begin
            del_d   = mask_q[in_xm1[LIST_AW-1:0]];
            add_d   = !mask_q[in_xm1[LIST_AW-1:0]];
            state_d = ST_WALK;
          end else begin
            del_d   = 1'b0;
            add_d   = 1'b0;
            state_d = ST_FINISH;
          end
        end
      end
      ST_WALK: begin
        // one list entry per cycle, then the self pair
        if (idx_q < cnt_q) begin
          iss_d.valid = 1'b1;
          iss_d.last  = (CNT_W'(idx_q + CNT_W'(1)) == cnt_q);
          idx_d       = idx_q + CNT_W'(1);
        end else begin
          iss_d.valid = 1'b1;
          iss_d.self  = 1'b1;
          state_d     = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!iss_q.valid) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        list_we = 1'b1;
        pos_we  = 1'b1;
        if (del_q) begin
          // the last member moves into the freed slot
          list_waddr          = pos_rdata;
          list_wdata          = last_q;
          pos_waddr           = last_q;
          pos_wdata           = pos_rdata;
          cnt_d               = cnt_q - CNT_W'(1);
          mask_d[x_m1[LIST_AW-1:0]] = 1'b0;
        end else begin
          cnt_d               = cnt_q + CNT_W'(1);
          mask_d[x_m1[LIST_AW-1:0]] = 1'b1;
        end
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // stage 1: form the sum and product addresses of the member at hand
  assign s1_y         = iss_q.self ? x_q : list_rdata;
  assign s1_go        = iss_q.valid && (iss_q.self || (s1_y != x_q));
  assign s1_sum       = (POS_AW+1)'(x_q) + (POS_AW+1)'(s1_y);
  assign s1_prod      = (2*POS_AW)'(x_q) * (2*POS_AW)'(s1_y);
  assign s1_sum_addr  = s1_sum[SUM_AW-1:0];
  assign s1_prod_addr = s1_prod[PROD_AW-1:0];

  always_comb begin
    s2_d.valid     = s1_go;
    s2_d.self      = iss_q.self;
    s2_d.sum_addr  = s1_sum_addr;
    s2_d.prod_addr = s1_prod_addr;
    last_d         = last_q;
    if (iss_q.valid && iss_q.last) begin
      last_d = list_rdata;
    end
  end

  // stage 2: count read-modify-write and distinct counters
  sspt_rep_upd u_sum_upd (
    .old_i  (sum_rdata),
    .add_i  (!del_q),
    .self_i (s2_q.self),
    .upd_o  (sum_upd)
  );

  sspt_rep_upd u_prod_upd (
    .old_i  (prod_rdata),
    .add_i  (!del_q),
    .self_i (s2_q.self),
    .upd_o  (prod_upd)
  );

  always_comb begin
    dsum_d  = dsum_q;
    dprod_d = dprod_q;
    if (s2_q.valid) begin
      if (sum_upd.rise) begin
        dsum_d = dsum_q + SUM_AW'(1);
      end else if (sum_upd.fall) begin
        dsum_d = dsum_q - SUM_AW'(1);
      end
      if (prod_upd.rise) begin
        dprod_d = dprod_q + PROD_AW'(1);
      end else if (prod_upd.fall) begin
        dprod_d = dprod_q - PROD_AW'(1);
      end
    end
  end

  // count memory write ports, shared with the clearing sweep
  always_comb begin
    if (clearing) begin
      sum_we     = ((CLR_AW+1)'(clr_q) < (CLR_AW+1)'(SUM_SLOTS));
      prod_we    = ((CLR_AW+1)'(clr_q) < (CLR_AW+1)'(PROD_SLOTS));
      sum_waddr  = clr_q[SUM_AW-1:0];
      prod_waddr = clr_q[PROD_AW-1:0];
      sum_wdata  = '0;
      prod_wdata = '0;
    end else begin
      sum_we     = s2_q.valid;
      prod_we    = s2_q.valid;
      sum_waddr  = s2_q.sum_addr;
      prod_waddr = s2_q.prod_addr;
      sum_wdata  = sum_upd.count;
      prod_wdata = prod_upd.count;
    end
  end

  assign pos_raddr = (state_q == ST_IDLE) ? in_x : x_q;

  // memories
  sspt_ram #(
    .WIDTH (POS_AW),
    .DEPTH (MAX_ELEM)
  ) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (list_we),
    .waddr_i (list_waddr),
    .wdata_i (list_wdata),
    .raddr_i (idx_q[LIST_AW-1:0]),
    .rdata_o (list_rdata)
  );

  sspt_ram #(
    .WIDTH (LIST_AW),
    .DEPTH (MAX_ELEM + 1)
  ) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (pos_waddr),
    .wdata_i (pos_wdata),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  sspt_ram #(
    .WIDTH (REP_W),
    .DEPTH (SUM_SLOTS)
  ) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (sum_waddr),
    .wdata_i (sum_wdata),
    .raddr_i (s1_sum_addr),
    .rdata_o (sum_rdata)
  );

  sspt_ram #(
    .WIDTH (REP_W),
    .DEPTH (PROD_SLOTS)
  ) u_prod_ram (
    .clk_i   (clk_i),
    .we_i    (prod_we),
    .waddr_i (prod_waddr),
    .wdata_i (prod_wdata),
    .raddr_i (s1_prod_addr),
    .rdata_o (prod_rdata)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      idx_q       <= '0;
      cnt_q       <= '0;
      mask_q      <= '0;
      dsum_q      <= '0;
      dprod_q     <= '0;
      iss_q       <= '0;
      s2_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      mask_q      <= mask_d;
      dsum_q      <= dsum_d;
      dprod_q     <= dprod_d;
      iss_q       <= iss_d;
      s2_q        <= s2_d;
      out_valid_q <= out_valid_d;
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    del_q  <= del_d;
    add_q  <= add_d;
    last_q <= last_d;
    if (out_load) begin
      set_size_q <= SETSZ_W'(cnt_q);
      sumset_q   <= SUMSET_W'(dsum_q);
      prodset_q  <= PRODSET_W'(dprod_q);
      added_q    <= add_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign set_size_o        = set_size_q;
  assign sumset_size_o     = sumset_q;
  assign productset_size_o = prodset_q;
  assign was_added_o       = added_q;

  // membership mask and member count agree
  a_mask_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(mask_q) == cnt_q)
    else $error("member mask and member count disagree");

  // a count update only runs inside the walk
  a_rmw_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_q.valid |-> (state_q == ST_WALK || state_q == ST_DRAIN))
    else $error("count update outside the member walk");

  // an out-of-range request leaves the set alone
  a_range_noop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !in_range) |=> (state_q == ST_FINISH && $stable(mask_q)))
    else $error("out-of-range request changed the set");

  // an insertion grows the member count by one
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_UPDATE && !del_q) |=> (cnt_q == CNT_W'($past(cnt_q) + 1'b1)))
    else $error("insertion did not grow the member count");

  // the count never passes the element range
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_ELEM))
    else $error("member count beyond element range");

endmodule

[tb/sumset_productset_tracker_core_tb.sv]
`timescale 1ns / 1ps

module sumset_productset_tracker_core_tb;
  import sspt_pkg::*;

  localparam int unsigned SET_MAX      = 63;
  localparam int unsigned SUM_SLOTS    = 2 * SET_MAX + 1;
  localparam int unsigned PROD_SLOTS   = SET_MAX * SET_MAX + 1;
  localparam int unsigned PHASE_ITEMS  = 633;
  localparam int unsigned SETTLE_CYC   = 100;
  localparam int unsigned LIMIT_CYCLES = 1_500_000;

  typedef struct packed {
    logic [SETSZ_W-1:0]   set_size;
    logic [SUMSET_W-1:0]  sumset_size;
    logic [PRODSET_W-1:0] productset_size;
    logic                 was_added;
  } tracker_result_t;

  typedef struct packed {
    logic [TOGGLE_W-1:0] elem;
    logic                typed;
    tracker_result_t     res;
  } directed_row_t;

  typedef enum int {FILL_ALL, DRAIN_ALL, GROW, SHRINK, SCATTER} burst_kind_e;

  // directed requests; typed rows carry a result known by hand
  localparam directed_row_t DIRECTED_ROWS [24] = '{
    '{6'd0,  1'b1, '{6'd0, 7'd0, 12'd0, 1'b0}},  // out of range on an empty set
    '{6'd63, 1'b1, '{6'd1, 7'd1, 12'd1, 1'b1}},  // largest element in
    '{6'd63, 1'b1, '{6'd0, 7'd0, 12'd0, 1'b0}},  // and out again
    '{6'd1,  1'b1, '{6'd1, 7'd1, 12'd1, 1'b1}},
    '{6'd63, 1'b1, '{6'd2, 7'd3, 12'd3, 1'b1}},
    '{6'd0,  1'b1, '{6'd2, 7'd3, 12'd3, 1'b0}},  // ignored with members present
    '{6'd1,  1'b1, '{6'd1, 7'd1, 12'd1, 1'b0}},  // removal moves last member
    '{6'd63, 1'b1, '{6'd0, 7'd0, 12'd0, 1'b0}},
    '{6'd32, 1'b0, '0},
    '{6'd16, 1'b0, '0},
    '{6'd8,  1'b0, '0},
    '{6'd4,  1'b0, '0},
    '{6'd2,  1'b0, '0},
    '{6'd1,  1'b0, '0},
    '{6'd3,  1'b0, '0},
    '{6'd5,  1'b0, '0},
    '{6'd42, 1'b0, '0},
    '{6'd21, 1'b0, '0},
    '{6'd0,  1'b0, '0},
    '{6'd42, 1'b0, '0},
    '{6'd32, 1'b0, '0},
    '{6'd63, 1'b0, '0},
    '{6'd62, 1'b0, '0},
    '{6'd31, 1'b0, '0}
  };

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [TOGGLE_W-1:0]  toggle_value_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [SETSZ_W-1:0]   set_size_o;
  logic [SUMSET_W-1:0]  sumset_size_o;
  logic [PRODSET_W-1:0] productset_size_o;
  logic                 was_added_o;

  sumset_productset_tracker_core DUT (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .toggle_value_i,
    .out_valid_o,
    .out_ready_i,
    .set_size_o,
    .sumset_size_o,
    .productset_size_o,
    .was_added_o
  );

  // predicted set state
  bit                  in_set [0:SET_MAX];
  logic [TOGGLE_W-1:0] slot_elem [0:SET_MAX-1];
  logic [TOGGLE_W-1:0] elem_slot [0:SET_MAX];
  int                  n_members;
  logic [REP_W-1:0]    sum_hits [0:SUM_SLOTS-1];
  logic [REP_W-1:0]    prod_hits [0:PROD_SLOTS-1];
  int                  n_sums;
  int                  n_prods;

  tracker_result_t expected_results [$];
  tracker_result_t want;

  int send_idle_pct;
  int recv_idle_pct;
  int err_count;
  int requests_sent;
  int results_checked;
  int largest_set;
  int cycle_count;

  always #5 clk_i = ~clk_i;

  // representation count updates, one per table
  function automatic void bump_sum(int idx, int d, bit up);
    logic [REP_W-1:0] prior;
    prior = sum_hits[idx];
    if (up) begin
      sum_hits[idx] = prior + REP_W'(d);
      if (prior == '0) n_sums++;
    end else begin
      sum_hits[idx] = prior - REP_W'(d);
      if (sum_hits[idx] == '0) n_sums--;
    end
  endfunction

  function automatic void bump_prod(int idx, int d, bit up);
    logic [REP_W-1:0] prior;
    prior = prod_hits[idx];
    if (up) begin
      prod_hits[idx] = prior + REP_W'(d);
      if (prior == '0) n_prods++;
    end else begin
      prod_hits[idx] = prior - REP_W'(d);
      if (prod_hits[idx] == '0) n_prods--;
    end
  endfunction

  // apply one toggle to the predicted set and report the sizes
  function automatic tracker_result_t apply_toggle(logic [TOGGLE_W-1:0] value);
    tracker_result_t res;
    int x;
    int y;
    int slot;
    int last_slot;
    int last;
    bit added;
    x = int'(value);
    added = 1'b0;
    if (x >= 1 && x <= SET_MAX) begin
      if (in_set[x]) begin
        bump_sum(2 * x, DELTA_SELF, 1'b0);
        bump_prod(x * x, DELTA_SELF, 1'b0);
        if (n_members > 0) begin
          slot = int'(elem_slot[x]);
          last_slot = n_members - 1;
          last = int'(slot_elem[last_slot]);
          slot_elem[slot] = TOGGLE_W'(last);
          elem_slot[last] = TOGGLE_W'(slot);
          n_members = last_slot;
        end
        for (int i = 0; i < n_members; i++) begin
          y = int'(slot_elem[i]);
          bump_sum(x + y, DELTA_PAIR, 1'b0);
          bump_prod(x * y, DELTA_PAIR, 1'b0);
        end
        in_set[x] = 1'b0;
      end else begin
        for (int i = 0; i < n_members; i++) begin
          y = int'(slot_elem[i]);
          bump_sum(x + y, DELTA_PAIR, 1'b1);
          bump_prod(x * y, DELTA_PAIR, 1'b1);
        end
        bump_sum(2 * x, DELTA_SELF, 1'b1);
        bump_prod(x * x, DELTA_SELF, 1'b1);
        if (n_members < SET_MAX) begin
          elem_slot[x] = TOGGLE_W'(n_members);
          slot_elem[n_members] = TOGGLE_W'(x);
          n_members++;
        end
        in_set[x] = 1'b1;
        added = 1'b1;
      end
    end
    res.set_size        = SETSZ_W'(n_members);
    res.sumset_size     = SUMSET_W'(n_sums);
    res.productset_size = PRODSET_W'(n_prods);
    res.was_added       = added;
    return res;
  endfunction

  // random element that is in the set (present) or missing from it
  function automatic logic [TOGGLE_W-1:0] pick_element(bit present);
    int start;
    int e;
    start = $urandom_range(SET_MAX, 1);
    for (int k = 0; k < SET_MAX; k++) begin
      e = ((start - 1 + k) % SET_MAX) + 1;
      if (in_set[e] == present) return TOGGLE_W'(e);
    end
    return '0;
  endfunction

  // drive one request, entered and left at a falling edge
  task automatic send_request(logic [TOGGLE_W-1:0] value, bit typed, tracker_result_t typed_res);
    tracker_result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    toggle_value_i <= value;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = apply_toggle(value);
    expected_results.push_back(typed ? typed_res : predicted);
    requests_sent++;
    if (n_members > largest_set) largest_set = n_members;
    @(negedge clk_i);
  endtask

  // hold off new requests until every result is back
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (expected_results.size() != 0);
  endtask

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_val, act_val);
      err_count++;
    end
  endtask

  // result side ready
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result checking
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual set %0d sums %0d prods %0d",
                 $time, set_size_o, sumset_size_o, productset_size_o);
        err_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("set_size", 32'(want.set_size), 32'(set_size_o));
        check_field("sumset_size", 32'(want.sumset_size), 32'(sumset_size_o));
        check_field("productset_size", 32'(want.productset_size),
                    32'(productset_size_o));
        check_field("was_added", 32'(want.was_added), 32'(was_added_o));
        results_checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    burst_kind_e         kind;
    logic [TOGGLE_W-1:0] value;
    int                  sent;
    int                  bursts;
    int                  burst_len;
    int                  k;
    int                  r;
    bit                  done;

    // predictor reset
    foreach (in_set[i]) in_set[i] = 1'b0;
    foreach (elem_slot[i]) elem_slot[i] = '0;
    foreach (sum_hits[i]) sum_hits[i] = '0;
    foreach (prod_hits[i]) prod_hits[i] = '0;
    n_members = 0;
    n_sums = 0;
    n_prods = 0;
    err_count = 0;
    requests_sent = 0;
    results_checked = 0;
    largest_set = 0;
    cycle_count = 0;
    send_idle_pct = 8;
    recv_idle_pct = 86;

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed requests
    foreach (DIRECTED_ROWS[i]) begin
      send_request(DIRECTED_ROWS[i].elem, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);
    end
    hold_until_drained();

    // random requests in three idling phases
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 8;
          recv_idle_pct = 86;
        end
        1: begin
          send_idle_pct = 86;
          recv_idle_pct = 8;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      sent = 0;
      bursts = 0;
      while (sent < PHASE_ITEMS) begin
        // each phase opens with a full fill and a full drain
        r = $urandom_range(9);
        if (bursts == 0) kind = FILL_ALL;
        else if (bursts == 1) kind = DRAIN_ALL;
        else if (r == 0) kind = FILL_ALL;
        else if (r == 1) kind = DRAIN_ALL;
        else if (r < 4) kind = GROW;
        else if (r < 6) kind = SHRINK;
        else kind = SCATTER;
        burst_len = $urandom_range(40, 5);
        k = 0;
        done = 1'b0;
        while (!done) begin
          case (kind)
            FILL_ALL:  done = (n_members == SET_MAX);
            DRAIN_ALL: done = (n_members == 0);
            GROW:      done = (n_members == SET_MAX) || (k >= burst_len);
            SHRINK:    done = (n_members == 0) || (k >= burst_len);
            default:   done = (k >= burst_len);
          endcase
          if (!done) begin
            case (kind)
              FILL_ALL, GROW:    value = pick_element(1'b0);
              DRAIN_ALL, SHRINK: value = pick_element(1'b1);
              default: begin
                value = ($urandom_range(99) < 3) ? TOGGLE_W'(0)
                                                 : TOGGLE_W'($urandom_range(SET_MAX, 1));
              end
            endcase
            send_request(value, 1'b0, '0);
            k++;
            sent++;
          end
        end
        bursts++;
      end
      hold_until_drained();
    end

    // let any stray result show up
    repeat (SETTLE_CYC) @(negedge clk_i);

    $display("%0d toggle requests sent, %0d results checked, largest set %0d members",
             requests_sent, results_checked, largest_set);
    $display("covered ignored requests, full fill and drain, and both-side stalls");
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
